[design/pds_pkg.sv]
`timescale 1ns / 1ps

package pds_pkg;

    localparam int MAX_REFS    = 64;
    localparam int MAX_CHANS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int STORE_DEPTH = MAX_REFS * MAX_CHANS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int REF_IDX_W   = $clog2(MAX_REFS);
    localparam int REF_CNT_W   = 7;
    localparam int CHAN_CNT_W  = 5;
    localparam int CHAN_POS_W  = $clog2(MAX_CHANS);
    localparam int TOTAL_W     = ADDR_W + 1;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int ACC_W       = 37;
    localparam int SCALE_W     = 16;
    localparam int PROD_W      = ACC_W + SCALE_W;
    localparam int DIST_W      = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd3;

    // Input commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             ign;
    } pair_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic active;
        logic tail;
    } cell_ctrl_t;

endpackage

[design/pds_ram.sv]
`timescale 1ns / 1ps

module pds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/pds_cell.sv]
`timescale 1ns / 1ps

module pds_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  pds_pkg::cell_ctrl_t ctrl,
    input  pds_pkg::pair_t     from_next,
    input  pds_pkg::pair_t     feedback,
    output pds_pkg::pair_t     pair_q
);

    pds_pkg::pair_t pair_reg;
    pds_pkg::pair_t pair_next;

    // Cells in use form a ring: each takes its neighbor's pair, and the tail
    // takes the head pair (updated during a sweep), so one full turn restores the order.
    always_comb begin
        pair_next = pair_reg;
        if (ctrl.clear) begin
            pair_next = '0;
        end else if (ctrl.shift && ctrl.active) begin
            pair_next = ctrl.tail ? feedback : from_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= '0;
        end else begin
            pair_reg <= pair_next;
        end
    end

    assign pair_q = pair_reg;

endmodule

[design/pairwise_sq_distance.sv]
`timescale 1ns / 1ps
// A reference value is written in its transfer cycle; the block is ready again next cycle.
// A query value keeps the input busy while the store is read once per reference (R = references
// in use) and the read pipeline drains; only then is the next value taken.
// After the last channel, R results leave at one per cycle while m_ready stays high.
// The time a query of C channels takes is set by the single store read port.
// Reset (aresetn, synchronous, active low) restores the control and configuration registers and clears all pairs.

module pairwise_sq_distance (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic signed [pds_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pds_pkg::REF_IDX_W-1:0]        m_ref_index,
    output logic [pds_pkg::DIST_W-1:0]           m_distance,
    output logic                                 m_ignored,
    output logic                                 m_last
);

    localparam int SB = pds_pkg::SAMPLE_BITS;
    localparam int NR = pds_pkg::MAX_REFS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [SB-1:0]                      ignore_reg, ignore_next;
    logic [pds_pkg::SCALE_W-1:0]        scale_reg, scale_next;
    logic [pds_pkg::REF_CNT_W-1:0]      ref_count_reg, ref_count_next;
    logic [pds_pkg::CHAN_CNT_W-1:0]     chan_count_reg, chan_count_next;

    logic [pds_pkg::ADDR_W-1:0]         load_pos_reg, load_pos_next;
    logic [pds_pkg::CHAN_POS_W-1:0]     qpos_reg, qpos_next;
    logic [SB-1:0]                      query_reg, query_next;
    logic [pds_pkg::ADDR_W-1:0]         addr_reg, addr_next;
    logic [pds_pkg::REF_IDX_W-1:0]      iss_cnt_reg, iss_cnt_next;
    logic                               issuing_reg, issuing_next;
    logic                               p1_valid_reg, p1_valid_next;
    logic                               p1_last_reg, p1_last_next;
    logic                               p2_valid_reg, p2_valid_next;
    logic                               p2_last_reg, p2_last_next;
    logic [pds_pkg::SQ_W-1:0]           p2_sq_reg, p2_sq_next;
    logic                               p2_hit_reg, p2_hit_next;
    logic [pds_pkg::REF_IDX_W-1:0]      emit_cnt_reg, emit_cnt_next;

    logic                               s1_valid_reg, s1_valid_next;
    logic [pds_pkg::PROD_W-1:0]         s1_prod_reg, s1_prod_next;
    logic                               s1_ign_reg, s1_ign_next;
    logic [pds_pkg::REF_IDX_W-1:0]      s1_idx_reg, s1_idx_next;
    logic                               s1_last_reg, s1_last_next;

    logic                               m_valid_reg, m_valid_next;
    logic [pds_pkg::DIST_W-1:0]         m_dist_reg, m_dist_next;
    logic                               m_ign_reg, m_ign_next;
    logic [pds_pkg::REF_IDX_W-1:0]      m_idx_reg, m_idx_next;
    logic                               m_last_reg, m_last_next;

    logic [pds_pkg::REF_CNT_W-1:0]      refs_use;
    logic [pds_pkg::CHAN_CNT_W-1:0]     chans_use;
    logic [pds_pkg::TOTAL_W-1:0]        total_use;
    logic [pds_pkg::REF_IDX_W-1:0]      ref_last;

    logic                               in_accept;
    logic                               accept_load;
    logic                               accept_query;
    logic                               qpos_over;
    logic [pds_pkg::ADDR_W-1:0]         wr_pos;
    logic [pds_pkg::TOTAL_W-1:0]        wr_pos_inc;

    logic [SB-1:0]                      ram_rdata;
    logic [SB:0]                        diff;
    logic [SB-1:0]                      diff_abs;

    logic                               out_ready;
    logic                               s1_ready;
    logic                               emit_step;
    logic                               emit_done;
    logic                               sweep_done;

    pds_pkg::pair_t                     cell_q [NR];
    pds_pkg::pair_t                     head;
    pds_pkg::pair_t                     head_upd;
    pds_pkg::pair_t                     feedback;
    logic                               cells_clear;
    logic                               cells_shift;

    // Register values out of range are clamped when used.
    always_comb begin
        if (ref_count_reg == '0) begin
            refs_use = pds_pkg::REF_CNT_W'(1);
        end else if (ref_count_reg > pds_pkg::REF_CNT_W'(NR)) begin
            refs_use = pds_pkg::REF_CNT_W'(NR);
        end else begin
            refs_use = ref_count_reg;
        end
        if (chan_count_reg == '0) begin
            chans_use = pds_pkg::CHAN_CNT_W'(1);
        end else if (chan_count_reg > pds_pkg::CHAN_CNT_W'(pds_pkg::MAX_CHANS)) begin
            chans_use = pds_pkg::CHAN_CNT_W'(pds_pkg::MAX_CHANS);
        end else begin
            chans_use = chan_count_reg;
        end
    end

    assign total_use = pds_pkg::TOTAL_W'(refs_use * chans_use);
    assign ref_last  = pds_pkg::REF_IDX_W'(refs_use - pds_pkg::REF_CNT_W'(1));

    assign s_ready      = (state_reg == ST_IDLE);
    assign in_accept    = s_valid && s_ready;
    assign accept_load  = in_accept && (s_cmd == pds_pkg::CMD_LOAD);
    assign accept_query = in_accept && (s_cmd == pds_pkg::CMD_QUERY);
    assign qpos_over    = (pds_pkg::CHAN_CNT_W'(qpos_reg) >= chans_use);

    // Reference load position wraps at the number of values in use.
    assign wr_pos     = (pds_pkg::TOTAL_W'(load_pos_reg) >= total_use) ? '0 : load_pos_reg;
    assign wr_pos_inc = pds_pkg::TOTAL_W'(wr_pos) + pds_pkg::TOTAL_W'(1);

    pds_ram #(
        .WIDTH (SB),
        .DEPTH (pds_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept_load),
        .wr_addr (wr_pos),
        .wr_data (s_sample),
        .rd_en   (issuing_reg),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    assign diff     = {query_reg[SB-1], query_reg} - {ram_rdata[SB-1], ram_rdata};
    assign diff_abs = diff[SB] ? SB'(-diff) : diff[SB-1:0];

    assign out_ready  = !m_valid_reg || m_ready;
    assign s1_ready   = !s1_valid_reg || out_ready;
    assign emit_step  = (state_reg == ST_EMIT) && s1_ready;
    assign emit_done  = emit_step && (emit_cnt_reg == ref_last);
    assign sweep_done = (state_reg == ST_SWEEP) && p2_valid_reg && p2_last_reg;

    // Cell 0 holds the pair of the reference currently at the head of the ring.
    assign head = cell_q[0];

    always_comb begin
        head_upd.ign = head.ign | p2_hit_reg;
        head_upd.acc = p2_hit_reg ? head.acc
                                  : head.acc + pds_pkg::ACC_W'(p2_sq_reg);
    end

    assign feedback    = (state_reg == ST_EMIT) ? head : head_upd;
    assign cells_clear = (accept_query && qpos_over) || emit_done;
    assign cells_shift = ((state_reg == ST_SWEEP) && p2_valid_reg) || emit_step;

    genvar gi;
    generate
        for (gi = 0; gi < NR; gi++) begin : g_cell
            pds_pkg::cell_ctrl_t ctrl;
            pds_pkg::pair_t      nbr;

            assign ctrl.clear  = cells_clear;
            assign ctrl.shift  = cells_shift;
            assign ctrl.active = (pds_pkg::REF_CNT_W'(gi) < refs_use);
            assign ctrl.tail   = (pds_pkg::REF_IDX_W'(gi) == ref_last);

            if (gi == NR - 1) begin : g_end
                assign nbr = '0;
            end else begin : g_mid
                assign nbr = cell_q[gi + 1];
            end

            pds_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .from_next (nbr),
                .feedback  (feedback),
                .pair_q    (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        ignore_next     = ignore_reg;
        scale_next      = scale_reg;
        ref_count_next  = ref_count_reg;
        chan_count_next = chan_count_reg;
        load_pos_next   = load_pos_reg;
        qpos_next       = qpos_reg;
        query_next      = query_reg;
        addr_next       = addr_reg;
        iss_cnt_next    = iss_cnt_reg;
        issuing_next    = issuing_reg;
        emit_cnt_next   = emit_cnt_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                pds_pkg::CFG_IGNORE_LEVEL: begin
                    ignore_next = cfg_wdata[SB-1:0];
                end
                pds_pkg::CFG_DISTANCE_SCALE: begin
                    scale_next = cfg_wdata[pds_pkg::SCALE_W-1:0];
                end
                pds_pkg::CFG_REFERENCE_COUNT: begin
                    ref_count_next = cfg_wdata[pds_pkg::REF_CNT_W-1:0];
                end
                pds_pkg::CFG_CHANNEL_COUNT: begin
                    chan_count_next = cfg_wdata[pds_pkg::CHAN_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end

        if (accept_load) begin
            load_pos_next = (wr_pos_inc >= total_use) ? '0 : wr_pos_inc[pds_pkg::ADDR_W-1:0];
        end

        // Store reads walk the references: address k*C + channel position.
        if (issuing_reg) begin
            addr_next    = addr_reg + pds_pkg::ADDR_W'(chans_use);
            iss_cnt_next = iss_cnt_reg + pds_pkg::REF_IDX_W'(1);
            if (iss_cnt_reg == ref_last) begin
                issuing_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept_query) begin
                    query_next   = s_sample;
                    qpos_next    = qpos_over ? '0 : qpos_reg;
                    addr_next    = pds_pkg::ADDR_W'(qpos_over ? '0 : qpos_reg);
                    iss_cnt_next = '0;
                    issuing_next = 1'b1;
                    state_next   = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    if (pds_pkg::CHAN_CNT_W'(qpos_reg) + pds_pkg::CHAN_CNT_W'(1) < chans_use) begin
                        qpos_next  = qpos_reg + pds_pkg::CHAN_POS_W'(1);
                        state_next = ST_IDLE;
                    end else begin
                        emit_cnt_next = '0;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_step) begin
                    emit_cnt_next = emit_cnt_reg + pds_pkg::REF_IDX_W'(1);
                end
                if (emit_done) begin
                    qpos_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read data pipeline: store read, then squared difference, then accumulate.
    always_comb begin
        p1_valid_next = issuing_reg;
        p1_last_next  = issuing_reg && (iss_cnt_reg == ref_last);
        p2_valid_next = p1_valid_reg;
        p2_last_next  = p1_last_reg;
        p2_sq_next    = p2_sq_reg;
        p2_hit_next   = p2_hit_reg;
        if (p1_valid_reg) begin
            p2_sq_next  = diff_abs * diff_abs;
            p2_hit_next = (query_reg == ignore_reg) || (ram_rdata == ignore_reg);
        end
    end

    // Scaling stage and output register.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_prod_next  = s1_prod_reg;
        s1_ign_next   = s1_ign_reg;
        s1_idx_next   = s1_idx_reg;
        s1_last_next  = s1_last_reg;
        if (s1_ready) begin
            s1_valid_next = emit_step;
            s1_prod_next  = head.acc * scale_reg;
            s1_ign_next   = head.ign;
            s1_idx_next   = emit_cnt_reg;
            s1_last_next  = (emit_cnt_reg == ref_last);
        end

        m_valid_next = m_valid_reg;
        m_dist_next  = m_dist_reg;
        m_ign_next   = m_ign_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        if (out_ready) begin
            m_valid_next = s1_valid_reg;
            // The product stays below 2^56, so the shifted value fits 48 bits.
            m_dist_next  = s1_ign_reg ? pds_pkg::DIST_MAX
                                      : pds_pkg::DIST_W'(s1_prod_reg >> 8);
            m_ign_next   = s1_ign_reg;
            m_idx_next   = s1_idx_reg;
            m_last_next  = s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ignore_reg     <= '0;
            scale_reg      <= pds_pkg::SCALE_W'(256);
            ref_count_reg  <= pds_pkg::REF_CNT_W'(64);
            chan_count_reg <= pds_pkg::CHAN_CNT_W'(16);
            load_pos_reg   <= '0;
            qpos_reg       <= '0;
            iss_cnt_reg    <= '0;
            issuing_reg    <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p1_last_reg    <= 1'b0;
            p2_valid_reg   <= 1'b0;
            p2_last_reg    <= 1'b0;
            emit_cnt_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ignore_reg     <= ignore_next;
            scale_reg      <= scale_next;
            ref_count_reg  <= ref_count_next;
            chan_count_reg <= chan_count_next;
            load_pos_reg   <= load_pos_next;
            qpos_reg       <= qpos_next;
            iss_cnt_reg    <= iss_cnt_next;
            issuing_reg    <= issuing_next;
            p1_valid_reg   <= p1_valid_next;
            p1_last_reg    <= p1_last_next;
            p2_valid_reg   <= p2_valid_next;
            p2_last_reg    <= p2_last_next;
            emit_cnt_reg   <= emit_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        query_reg   <= query_next;
        addr_reg    <= addr_next;
        p2_sq_reg   <= p2_sq_next;
        p2_hit_reg  <= p2_hit_next;
        s1_prod_reg <= s1_prod_next;
        s1_ign_reg  <= s1_ign_next;
        s1_idx_reg  <= s1_idx_next;
        s1_last_reg <= s1_last_next;
        m_dist_reg  <= m_dist_next;
        m_ign_reg   <= m_ign_next;
        m_idx_reg   <= m_idx_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_ref_index = m_idx_reg;
    assign m_distance  = m_dist_reg;
    assign m_ignored   = m_ign_reg;
    assign m_last      = m_last_reg;

endmodule
